### rtl/assert_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/dsfr_pkg.sv
package dsfr_pkg;

   // Incoming action codes (req_tuser).
   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_BYTE    = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;

   // Register indexes on the csr port.
   localparam logic CSR_ATTEMPT_LIMIT = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [7:0]  SYNC_BYTE     = 8'h5A;
   localparam logic [7:0]  TYPE_BYTE     = 8'h15;
   localparam logic [7:0]  LEN_BYTE      = 8'h03;
   localparam logic [15:0] NOT_FOUND     = 16'hFFFF;
   localparam logic [7:0]  LIMIT_RESET   = 8'd200;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
   localparam logic [2:0]  HEADER_LEN    = 3'd4;
   localparam logic [2:0]  CHECKSUM_POS  = 3'd7;
   localparam logic [2:0]  DIST_HI_POS   = 3'd4;
   localparam logic [2:0]  DIST_LO_POS   = 3'd5;

   // Classified command handed from front to back.
   typedef enum logic [1:0] {
      KIND_REQUEST,
      KIND_BYTE,
      KIND_TICK
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [7:0] header_byte(input logic [1:0] pos);
      logic [7:0] value;
      case (pos)
         2'd0, 2'd1: value = SYNC_BYTE;
         2'd2:       value = TYPE_BYTE;
         default:    value = LEN_BYTE;
      endcase
      return value;
   endfunction

endpackage

### rtl/dsfr_front.sv
module dsfr_front (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_byte,
   input  logic               queue_full,
   output logic               push,
   output dsfr_pkg::cmd_type  push_cmd
);

   logic known;

   // Map action codes onto command kinds; the unused code is swallowed here.
   always_comb begin
      known         = 1'b1;
      push_cmd.kind = dsfr_pkg::KIND_REQUEST;
      push_cmd.data = req_byte;
      case (req_action)
         dsfr_pkg::ACT_REQUEST: begin
            push_cmd.kind = dsfr_pkg::KIND_REQUEST;
         end
         dsfr_pkg::ACT_BYTE: begin
            push_cmd.kind = dsfr_pkg::KIND_BYTE;
         end
         dsfr_pkg::ACT_TICK: begin
            push_cmd.kind = dsfr_pkg::KIND_TICK;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && known;

endmodule

### rtl/dsfr_queue.sv
`include "assert_macros.svh"

module dsfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dsfr_pkg::cmd_type  push_cmd,
   output logic               full,
   output logic               not_empty,
   input  logic               pop,
   output dsfr_pkg::cmd_type  head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsfr_pkg::cmd_type slots [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count past depth")
   `ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && !not_empty, "pop from empty queue")

endmodule

### rtl/dsfr_back.sv
`include "assert_macros.svh"

module dsfr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata,
   input  logic               cmd_valid,
   input  dsfr_pkg::cmd_type  cmd,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_distance,
   output logic               rsp_found
);

   logic [7:0]  limit_ff,    limit_in;
   logic [7:0]  timeout_ff,  timeout_in;
   logic        busy_ff,     busy_in;
   logic [2:0]  pos_ff,      pos_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [7:0]  timer_ff,    timer_in;
   logic [7:0]  sum_ff,      sum_in;
   logic [15:0] dist_ff,     dist_in;
   logic        valid_ff,    valid_in;
   logic [15:0] out_dist_ff, out_dist_in;
   logic        out_found_ff, out_found_in;

   logic       fail_now;
   logic       done_ok;
   logic       done_none;
   logic [7:0] att_next;
   logic [7:0] timer_next;

   // Any command may produce a result, so only retire into a free output slot.
   assign pop = cmd_valid && (!valid_ff || rsp_tready);

   assign att_next   = (attempts_ff != 8'hFF) ? attempts_ff + 8'd1 : attempts_ff;
   assign timer_next = (timer_ff != 8'hFF) ? timer_ff + 8'd1 : timer_ff;

   always_comb begin
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         if (csr_index == dsfr_pkg::CSR_ATTEMPT_LIMIT) begin
            limit_in = csr_wdata;
         end else begin
            timeout_in = csr_wdata;
         end
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      pos_in      = pos_ff;
      attempts_in = attempts_ff;
      timer_in    = timer_ff;
      sum_in      = sum_ff;
      dist_in     = dist_ff;
      fail_now    = 1'b0;
      done_ok     = 1'b0;
      done_none   = 1'b0;

      if (pop) begin
         case (cmd.kind)
            dsfr_pkg::KIND_REQUEST: begin
               busy_in     = 1'b1;
               attempts_in = '0;
               pos_in      = '0;
               timer_in    = '0;
               sum_in      = '0;
               dist_in     = '0;
               done_none   = (limit_ff == 8'd0);
            end
            dsfr_pkg::KIND_BYTE: begin
               if (busy_ff) begin
                  if (pos_ff < dsfr_pkg::HEADER_LEN) begin
                     if (cmd.data != dsfr_pkg::header_byte(pos_ff[1:0])) begin
                        fail_now = 1'b1;
                     end else begin
                        sum_in   = sum_ff + cmd.data;
                        pos_in   = pos_ff + 3'd1;
                        timer_in = '0;
                     end
                  end else if (pos_ff != dsfr_pkg::CHECKSUM_POS) begin
                     if (pos_ff == dsfr_pkg::DIST_HI_POS) begin
                        dist_in = {cmd.data, 8'h00};
                     end else if (pos_ff == dsfr_pkg::DIST_LO_POS) begin
                        dist_in = {dist_ff[15:8], cmd.data};
                     end
                     sum_in = sum_ff + cmd.data;
                     pos_in = pos_ff + 3'd1;
                  end else if (cmd.data != sum_ff) begin
                     fail_now = 1'b1;
                  end else begin
                     done_ok = 1'b1;
                  end
               end
            end
            dsfr_pkg::KIND_TICK: begin
               if (busy_ff) begin
                  timer_in = timer_next;
                  fail_now = (timer_next >= timeout_ff);
               end
            end
            default: begin
            end
         endcase
      end

      if (fail_now) begin
         attempts_in = att_next;
         pos_in      = '0;
         timer_in    = '0;
         sum_in      = '0;
         dist_in     = '0;
         done_none   = (att_next >= limit_ff);
      end

      if (done_ok || done_none) begin
         busy_in  = 1'b0;
         pos_in   = '0;
         timer_in = '0;
         sum_in   = '0;
         dist_in  = '0;
      end
   end

   // Output register: load on a result, clear when taken.
   always_comb begin
      valid_in     = valid_ff;
      out_dist_in  = out_dist_ff;
      out_found_in = out_found_ff;
      if (done_ok || done_none) begin
         valid_in     = 1'b1;
         out_dist_in  = done_ok ? dist_ff : dsfr_pkg::NOT_FOUND;
         out_found_in = done_ok;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= dsfr_pkg::LIMIT_RESET;
         timeout_ff  <= dsfr_pkg::TIMEOUT_RESET;
         busy_ff     <= 1'b0;
         pos_ff      <= '0;
         attempts_ff <= '0;
         timer_ff    <= '0;
         sum_ff      <= '0;
         dist_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         timeout_ff  <= timeout_in;
         busy_ff     <= busy_in;
         pos_ff      <= pos_in;
         attempts_ff <= attempts_in;
         timer_ff    <= timer_in;
         sum_ff      <= sum_in;
         dist_ff     <= dist_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_dist_ff  <= out_dist_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_distance = out_dist_ff;
   assign rsp_found    = out_found_ff;

   `ASSERT_ALWAYS(a_pos_needs_busy, clock, reset, (pos_ff != 3'd0) |-> busy_ff, "frame position set while idle")
   `ASSERT_ALWAYS(a_miss_code, clock, reset, (valid_ff && !out_found_ff) |-> (out_dist_ff == dsfr_pkg::NOT_FOUND), "miss result without not-found code")
   `ASSERT_ALWAYS(a_zero_limit, clock, reset, (pop && cmd.kind == dsfr_pkg::KIND_REQUEST && limit_ff == 8'd0) |=> (valid_ff && !out_found_ff && !busy_ff), "zero limit request did not answer at once")

endmodule

### rtl/distance_sensor_frame_reader.sv
// Sensor frame reader. Each input word carries an action in req_tuser (read request, received
// serial byte in req_tdata, or timer tick). A read request starts a search for the frame
// 5A 5A 15 03 d0 d1 d2 cs, where cs is the 8-bit sum of the seven bytes before it; each header
// byte must arrive within timeout_ticks ticks, the data and checksum bytes share one window of
// that length. A bad byte or a timeout costs one attempt and the search restarts with the next
// byte. The block answers once per search: distance {d0,d1} with found=1, or 0xFFFF with
// found=0 when attempt_limit attempts have failed. Bytes and ticks while idle are dropped.
// Throughput: one word per cycle while the queue has room. A front stage classifies words
// into a QUEUE_DEPTH-entry queue; the back end retires one queued command per cycle whenever
// its output register is empty or being taken. A word is written into the queue on the edge
// that accepts it; the back end then loads its result into the output register that drives
// rsp once that register is free. req_tready falls only when the queue is full, i.e. after
// rsp has been stalled long enough to back it up. Configuration is taken on any cycle with
// csr_we high and is meant to change only while no search is in progress.
module distance_sensor_frame_reader #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,

   // Configuration writes: index 0 attempt_limit, index 1 timeout_ticks.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [1:0]  req_tuser,   // [1:0] action

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] distance
   output logic        rsp_tuser    // [0] found
);

   logic              push;
   dsfr_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              queue_not_empty;
   logic              pop;
   dsfr_pkg::cmd_type head_cmd;

   // Front: decode action, drop unused code, push into queue.
   dsfr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_byte   (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Decoupling queue between front and back.
   dsfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head_cmd  (head_cmd)
   );

   // Back: frame search state, config registers and output register.
   dsfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_valid    (queue_not_empty),
      .cmd          (head_cmd),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_distance (rsp_tdata),
      .rsp_found    (rsp_tuser)
   );

endmodule

### sim/distance_sensor_frame_reader_tb.sv
`timescale 1ns / 100ps

module distance_sensor_frame_reader_tb;

   // Action code the block must drop, no package name for it.
   localparam logic [1:0]  ACT_UNUSED     = 2'd3;
   // Header in send order, byte 0 in the low bits.
   localparam logic [31:0] FRAME_HEADER   = {dsfr_pkg::LEN_BYTE, dsfr_pkg::TYPE_BYTE,
                                             dsfr_pkg::SYNC_BYTE, dsfr_pkg::SYNC_BYTE};
   // Frame byte index meaning "leave the frame intact".
   localparam int          NO_FAULT       = 8;
   // Settle time before register writes and at the end: pipe plus queue.
   localparam int          DRAIN_CYCLES   = 12;
   // Cycles with no word moving on either side before the run is declared hung.
   localparam int          STALL_LIMIT    = 5000;
   localparam int          PHASES         = 10;
   localparam int          PHASE_WORDS    = 140;
   // Per-phase register settings for the fixed phases, phase 0 in the low byte.
   localparam logic [63:0] PHASE_LIMITS   =
      {8'd17, 8'd0, 8'd1, 8'd255, 8'd3, 8'd200, 8'd255, 8'd1};
   localparam logic [63:0] PHASE_TIMEOUTS =
      {8'd0, 8'd5, 8'd255, 8'd1, 8'd2, 8'd10, 8'd255, 8'd1};

   typedef struct packed {
      logic [15:0] distance;
      logic        found;
   } reading_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [7:0]  csr_wdata  = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_value
   logic [1:0]  req_tuser  = 2'd0;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [15:0] distance
   logic        rsp_tuser;            // [0] found

   distance_sensor_frame_reader u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Frame search predictor: own copy of registers and search state.
   // ---------------------------------------------------------------------
   logic [7:0]  limit_cfg;
   logic [7:0]  timeout_cfg;
   logic        searching;
   logic [2:0]  frame_pos;      // next frame byte expected
   logic [7:0]  attempts;
   logic [7:0]  wait_ticks;     // ticks in current header wait or data window
   logic [7:0]  sum_acc;
   logic [15:0] dist_acc;

   reading_type pending_readings[$];
   int unsigned live_words;     // words the block actually acts on
   int unsigned mismatches;
   int unsigned quiet_cycles;
   bit          gaps_on;

   function automatic void clear_frame();
      frame_pos  = 3'd0;
      wait_ticks = 8'd0;
      sum_acc    = 8'd0;
      dist_acc   = 16'd0;
   endfunction

   // Any answer closes the search.
   function automatic void post_reading(logic [15:0] distance, logic found);
      pending_readings.push_back('{distance: distance, found: found});
      searching = 1'b0;
      clear_frame();
   endfunction

   function automatic void count_failure();
      if (attempts != 8'hFF)
         attempts++;
      if (attempts >= limit_cfg)
         post_reading(dsfr_pkg::NOT_FOUND, 1'b0);
      else
         clear_frame();
   endfunction

   function automatic void predict_word(logic [1:0] act, logic [7:0] value);
      if (act == dsfr_pkg::ACT_REQUEST || (searching && act != ACT_UNUSED))
         live_words++;
      case (act)
         dsfr_pkg::ACT_REQUEST: begin
            // also covers a request in mid-search: fresh start, attempts cleared
            searching = 1'b1;
            attempts  = 8'd0;
            clear_frame();
            if (limit_cfg == 8'd0)
               post_reading(dsfr_pkg::NOT_FOUND, 1'b0);
         end
         dsfr_pkg::ACT_BYTE: if (searching) begin
            if (frame_pos < dsfr_pkg::HEADER_LEN) begin
               // bad header byte is dropped, not retried as a first sync byte
               if (value != FRAME_HEADER[8*frame_pos[1:0] +: 8]) begin
                  count_failure();
               end else begin
                  sum_acc    = sum_acc + value;
                  frame_pos  = frame_pos + 3'd1;
                  wait_ticks = 8'd0;
               end
            end else if (frame_pos < dsfr_pkg::CHECKSUM_POS) begin
               // data bytes share one window: timer keeps running
               if (frame_pos == dsfr_pkg::DIST_HI_POS)
                  dist_acc = {value, 8'h00};
               else if (frame_pos == dsfr_pkg::DIST_LO_POS)
                  dist_acc[7:0] = value;
               sum_acc   = sum_acc + value;
               frame_pos = frame_pos + 3'd1;
            end else if (value != sum_acc) begin
               count_failure();
            end else begin
               post_reading(dist_acc, 1'b1);
            end
         end
         dsfr_pkg::ACT_TICK: if (searching) begin
            if (wait_ticks != 8'hFF)
               wait_ticks++;
            // a zero timeout trips on the first tick, same as one
            if (wait_ticks >= timeout_cfg)
               count_failure();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Pacing: mostly short gaps, a few long ones, none when gaps_on is low.
   // ---------------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Receiver stalls; one assignment per falling edge at most.
   initial begin : rsp_pacer
      int unsigned hold_len;
      int unsigned stall_len;
      forever begin
         hold_len  = $urandom_range(1, 8);
         stall_len = gaps_on ? pick_gap() : 0;
         if (stall_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (hold_len) @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Word driver. Entered and left at a falling edge; valid stays high
   // into the next word when there is no gap.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [1:0] act, input logic [7:0] value);
      int unsigned gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= act;
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_word(act, value);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_word(dsfr_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   // One frame with a correct checksum, unless bad_at picks a byte to spoil.
   // with_ticks sprinkles ticks that stay inside every timeout.
   task automatic send_frame(input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2, input int bad_at,
                             input bit with_ticks);
      logic [7:0]  frame_bytes [8];
      logic [7:0]  csum;
      int unsigned safe;
      int unsigned window_left;
      int unsigned n;
      for (int i = 0; i < 4; i++)
         frame_bytes[i] = FRAME_HEADER[8*i +: 8];
      frame_bytes[4] = d0;
      frame_bytes[5] = d1;
      frame_bytes[6] = d2;
      csum = 8'h00;
      for (int i = 0; i < 7; i++)
         csum = csum + frame_bytes[i];
      frame_bytes[7] = csum;
      if (bad_at < NO_FAULT) begin
         // a stray sync byte is the nasty case past byte 1
         if (bad_at >= 2 && frame_bytes[bad_at] != dsfr_pkg::SYNC_BYTE &&
             $urandom_range(0, 2) == 0)
            frame_bytes[bad_at] = dsfr_pkg::SYNC_BYTE;
         else
            frame_bytes[bad_at] = frame_bytes[bad_at] ^ 8'($urandom_range(1, 255));
      end
      safe        = (timeout_cfg > 8'd1) ? timeout_cfg - 1 : 0;
      window_left = safe;
      for (int i = 0; i < 8; i++) begin
         if (with_ticks) begin
            if (i < 4) begin
               n = $urandom_range(0, (safe < 3) ? safe : 3);
            end else begin
               n = $urandom_range(0, (window_left < 2) ? window_left : 2);
               window_left = window_left - n;
            end
            send_ticks(n);
         end
         send_word(dsfr_pkg::ACT_BYTE, frame_bytes[i]);
      end
   endtask

   // Wait out every pending reading plus pipeline slack, valid low.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Registers change only with no search open and the pipe empty.
   task automatic set_config(input logic [7:0] new_limit, input logic [7:0] new_timeout);
      if (searching) begin
         send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
         send_frame(8'h00, 8'h00, 8'h00, NO_FAULT, 1'b0);
      end
      drain_pipeline();
      csr_index <= dsfr_pkg::CSR_ATTEMPT_LIMIT;
      csr_wdata <= new_limit;
      csr_we    <= 1'b1;
      @(posedge clock);
      limit_cfg = new_limit;
      @(negedge clock);
      csr_index <= dsfr_pkg::CSR_TIMEOUT_TICKS;
      csr_wdata <= new_timeout;
      @(posedge clock);
      timeout_cfg = new_timeout;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: idle words dropped, restart while busy, payload extremes.
   task automatic test_idle_and_frames();
      gaps_on = 1'b1;
      send_word(dsfr_pkg::ACT_BYTE, 8'hFF);
      send_word(dsfr_pkg::ACT_TICK, 8'h00);
      send_word(ACT_UNUSED, 8'hA5);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      send_word(dsfr_pkg::ACT_REQUEST, 8'hFF);
      send_word(ACT_UNUSED, 8'h5A);
      send_frame(8'hFF, 8'hFF, 8'hFF, NO_FAULT, 1'b0);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_frame(8'h00, 8'h00, 8'h00, NO_FAULT, 1'b1);
   endtask

   // Single attempt: bad header byte, zero timeout, bad checksum.
   task automatic test_single_faults();
      set_config(8'd1, 8'd0);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_word(dsfr_pkg::ACT_BYTE, 8'h00);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_word(dsfr_pkg::ACT_TICK, 8'h00);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_frame(8'h12, 8'h34, 8'h56, 7, 1'b0);
   endtask

   // Failed sync byte must not restart the frame; data window timeout.
   task automatic test_resync();
      set_config(8'd2, 8'd3);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::TYPE_BYTE);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      for (int i = 0; i < 4; i++)
         send_word(dsfr_pkg::ACT_BYTE, FRAME_HEADER[8*i +: 8]);
      send_ticks(2);
      send_word(dsfr_pkg::ACT_BYTE, 8'hAA);
      send_ticks(4);
   endtask

   // Zero limit answers at once; limit 255 needs 255 failures.
   task automatic test_limit_extremes();
      set_config(8'd0, 8'd255);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      send_word(dsfr_pkg::ACT_BYTE, dsfr_pkg::SYNC_BYTE);
      set_config(8'd255, 8'd255);
      send_word(dsfr_pkg::ACT_REQUEST, 8'h00);
      repeat (255) send_word(dsfr_pkg::ACT_BYTE, 8'h00);
   endtask

   // One search: request, then up to 12 attempt steps while it stays open.
   task automatic run_search();
      int unsigned roll;
      int unsigned steps;
      int unsigned k;
      if ($urandom_range(0, 9) == 0) begin
         send_word(dsfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
         send_ticks(1);
      end
      send_word(dsfr_pkg::ACT_REQUEST, 8'($urandom_range(0, 255)));
      steps = 0;
      while (searching && steps < 12) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), NO_FAULT, 1'($urandom_range(0, 1)));
         end else if (roll < 65) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), int'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
         end else if (roll < 75) begin
            // partial header then let the wait run out
            k = $urandom_range(0, 4);
            for (int i = 0; i < k; i++)
               send_word(dsfr_pkg::ACT_BYTE, FRAME_HEADER[8*i +: 8]);
            send_ticks((timeout_cfg == 8'd0) ? 1 : timeout_cfg);
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 3))
               send_word(dsfr_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
         end else if (roll < 90) begin
            send_word(ACT_UNUSED, 8'($urandom_range(0, 255)));
         end else if (roll < 95) begin
            send_word(dsfr_pkg::ACT_REQUEST, 8'($urandom_range(0, 255)));
         end else begin
            send_ticks(1);
         end
         steps++;
      end
   endtask

   // Random searches across register settings, extremes first.
   task automatic test_random_searches();
      int unsigned target;
      logic [7:0]  lim;
      logic [7:0]  tmo;
      for (int p = 0; p < PHASES; p++) begin
         if (p < 8) begin
            lim = PHASE_LIMITS[8*p +: 8];
            tmo = PHASE_TIMEOUTS[8*p +: 8];
         end else begin
            lim = 8'($urandom_range(1, 255));
            tmo = 8'($urandom_range(1, 255));
         end
         set_config(lim, tmo);
         gaps_on = (p % 3 != 2);
         target  = live_words + PHASE_WORDS;
         while (live_words < target)
            run_search();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every accepted word on rsp against the oldest reading.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reading: distance %h found %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata !== want.distance || rsp_tuser !== want.found) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reading mismatch: distance exp %h got %h, found exp %b got %b",
                           want.distance, rsp_tdata, want.found, rsp_tuser);
            end
         end
      end
   end

   // Hang detector: nothing moving on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("distance_sensor_frame_reader verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      limit_cfg    = dsfr_pkg::LIMIT_RESET;
      timeout_cfg  = dsfr_pkg::TIMEOUT_RESET;
      searching    = 1'b0;
      attempts     = 8'd0;
      live_words   = 0;
      mismatches   = 0;
      quiet_cycles = 0;
      gaps_on      = 1'b1;
      clear_frame();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_and_frames();
      test_single_faults();
      test_resync();
      test_limit_extremes();
      test_random_searches();

      drain_pipeline();
      if (pending_readings.size() != 0) begin
         $display("readings never produced: %0d", pending_readings.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("distance_sensor_frame_reader verification clean");
      else
         $display("distance_sensor_frame_reader verification failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/dsfr_pkg.sv
rtl/dsfr_front.sv
rtl/dsfr_queue.sv
rtl/dsfr_back.sv
rtl/distance_sensor_frame_reader.sv
sim/distance_sensor_frame_reader_tb.sv
